/* src/kbd_xlat_pkg.sv */
package kbd_xlat_pkg;

  // Command queue depth in bytes
  localparam int unsigned QUEUE_DEPTH = 32;

  // Keyboard bytes with a meaning of their own
  localparam logic [7:0] LED_CMD        = 8'hED;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
  localparam logic [7:0] SC_NUM_MAKE    = 8'h45;
  localparam logic [7:0] SC_SCROLL_MAKE = 8'h46;
  localparam logic [7:0] KBD_ACK        = 8'hFA;
  localparam logic [7:0] KBD_RESEND     = 8'hFE;

  // Characters produced outside the tables
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_CASE_OFS  = 8'h20;

  // LED bits
  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  // One queue row: LED command, optionally followed by its LED byte
  typedef struct packed {
    logic       has_led;
    logic [2:0] leds;
  } queue_row_t;

  // Requests from the translator to the command queue
  typedef struct packed {
    logic       restart;
    logic [2:0] restart_leds;
    logic       push;
    logic [2:0] push_leds;
    logic       pop;
  } queue_req_t;

  // Queue status, valid in the same cycle as the request
  typedef struct packed {
    logic       avail;
    logic [7:0] head_byte;
  } queue_stat_t;

  // Scan code to character, no shift held
  function automatic logic [7:0] plain_map(input logic [6:0] idx);
    logic [7:0] ch;
    case (idx)
      7'h02: ch = 8'h31;
      7'h03: ch = 8'h32;
      7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;
      7'h06: ch = 8'h35;
      7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;
      7'h09: ch = 8'h38;
      7'h0A: ch = 8'h39;
      7'h0B: ch = 8'h30;
      7'h0C: ch = 8'h2D;
      7'h0D: ch = 8'h5E;
      7'h10: ch = 8'h51;
      7'h11: ch = 8'h57;
      7'h12: ch = 8'h45;
      7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;
      7'h15: ch = 8'h59;
      7'h16: ch = 8'h55;
      7'h17: ch = 8'h49;
      7'h18: ch = 8'h4F;
      7'h19: ch = 8'h50;
      7'h1A: ch = 8'h40;
      7'h1B: ch = 8'h5B;
      7'h1E: ch = 8'h41;
      7'h1F: ch = 8'h53;
      7'h20: ch = 8'h44;
      7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;
      7'h23: ch = 8'h48;
      7'h24: ch = 8'h4A;
      7'h25: ch = 8'h4B;
      7'h26: ch = 8'h4C;
      7'h27: ch = 8'h3B;
      7'h28: ch = 8'h3A;
      7'h2B: ch = 8'h5D;
      7'h2C: ch = 8'h5A;
      7'h2D: ch = 8'h58;
      7'h2E: ch = 8'h43;
      7'h2F: ch = 8'h56;
      7'h30: ch = 8'h42;
      7'h31: ch = 8'h4E;
      7'h32: ch = 8'h4D;
      7'h33: ch = 8'h2C;
      7'h34: ch = 8'h2E;
      7'h35: ch = 8'h2F;
      7'h37: ch = 8'h2A;
      7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;
      7'h48: ch = 8'h38;
      7'h49: ch = 8'h39;
      7'h4A: ch = 8'h2D;
      7'h4B: ch = 8'h34;
      7'h4C: ch = 8'h35;
      7'h4D: ch = 8'h36;
      7'h4E: ch = 8'h2B;
      7'h4F: ch = 8'h31;
      7'h50: ch = 8'h32;
      7'h51: ch = 8'h33;
      7'h52: ch = 8'h30;
      7'h53: ch = 8'h2E;
      7'h73: ch = 8'h5C;
      7'h7D: ch = 8'h5C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Scan code to character, a shift key held; keys not listed match the plain map
  function automatic logic [7:0] shifted_map(input logic [6:0] idx);
    logic [7:0] ch;
    case (idx)
      7'h02: ch = 8'h21;
      7'h03: ch = 8'h22;
      7'h04: ch = 8'h23;
      7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;
      7'h07: ch = 8'h26;
      7'h08: ch = 8'h27;
      7'h09: ch = 8'h28;
      7'h0A: ch = 8'h29;
      7'h0B: ch = 8'h7E;
      7'h0C: ch = 8'h3D;
      7'h0D: ch = 8'h7E;
      7'h1A: ch = 8'h60;
      7'h1B: ch = 8'h7B;
      7'h27: ch = 8'h2B;
      7'h28: ch = 8'h2A;
      7'h2B: ch = 8'h7D;
      7'h33: ch = 8'h3C;
      7'h34: ch = 8'h3E;
      7'h35: ch = 8'h3F;
      7'h73: ch = 8'h5F;
      7'h7D: ch = 8'h7C;
      default: ch = plain_map(idx);
    endcase
    return ch;
  endfunction

endpackage

/* src/keyboard_scan_code_translator_unit.sv */
// Set-1 scan code to ASCII translator with the lock LED command channel.
// Each request on s_axis is one raw keyboard byte; each gives exactly one
// result on m_axis with the character (if any), the byte to send to the
// keyboard now (if any), and the LED and shift state after that byte.
// One request is taken per clock while m_axis accepts results; each passes
// through the input register, then the result register, to m_axis. While a
// result waits for m_axis_tready the block takes one more request into its
// input register and then holds s_axis_tready low. Lock keys queue
// the LED command and LED byte in a command queue of QUEUE_DEPTH bytes held
// in a RAM behind a front-row register; bytes that do not fit are dropped.
// A write on the cfg port restarts the block with new LED bits; write it
// only while no request is in flight.
module keyboard_scan_code_translator_unit #(
  parameter int unsigned QUEUE_DEPTH = kbd_xlat_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,     // initial_leds
  // Keyboard bytes in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
  // Results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] char_valid, [8:1] char_code,
                                      // [9] send_valid, [17:10] send_byte,
                                      // [20:18] led_bits, [22:21] shift_bits,
                                      // [23] zero
);

  logic        in_vld_q;
  logic [7:0]  in_code_q;
  logic        out_vld_q;
  logic [23:0] out_data_q;

  logic [1:0]  shift_q, shift_d;
  logic [2:0]  leds_q, leds_d;
  logic        await_q, await_d;
  logic [7:0]  pend_q, pend_d;

  logic        cfg_wr, in_take, advance, process;
  logic [7:0]  ch_raw, ch;
  logic        is_alpha;
  logic [2:0]  toggle;
  logic        resend_hit, await_mid, pop;
  logic        send_vld;
  logic [7:0]  send_byte;

  kbd_xlat_pkg::queue_req_t  q_req;
  kbd_xlat_pkg::queue_stat_t q_stat;

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i;
  assign advance       = !out_vld_q || m_axis_tready;
  assign process       = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || process;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Character lookup
  always_comb begin
    if (in_code_q[7]) begin
      ch_raw = 8'h00;
    end else if (shift_q == 2'b00) begin
      ch_raw = kbd_xlat_pkg::plain_map(in_code_q[6:0]);
    end else begin
      ch_raw = kbd_xlat_pkg::shifted_map(in_code_q[6:0]);
    end
    is_alpha = (ch_raw >= kbd_xlat_pkg::CH_UPPER_A) && (ch_raw <= kbd_xlat_pkg::CH_UPPER_Z);
    // Lower case unless exactly one of caps lock and shift holds
    if (is_alpha && (leds_q[2] == (shift_q != 2'b00))) begin
      ch = ch_raw + kbd_xlat_pkg::CH_CASE_OFS;
    end else begin
      ch = ch_raw;
    end
    if (in_code_q == kbd_xlat_pkg::SC_BACKSPACE) begin
      ch = kbd_xlat_pkg::CH_BACKSPACE;
    end
    if (in_code_q == kbd_xlat_pkg::SC_ENTER) begin
      ch = kbd_xlat_pkg::CH_NEWLINE;
    end
  end

  // Shift, lock and acknowledge handling
  always_comb begin
    shift_d    = shift_q;
    toggle     = 3'b000;
    await_mid  = await_q;
    resend_hit = 1'b0;
    unique case (in_code_q)
      kbd_xlat_pkg::SC_LSHIFT_MAKE: shift_d = shift_q | 2'b01;
      kbd_xlat_pkg::SC_RSHIFT_MAKE: shift_d = shift_q | 2'b10;
      kbd_xlat_pkg::SC_LSHIFT_BRK:  shift_d = shift_q & 2'b10;
      kbd_xlat_pkg::SC_RSHIFT_BRK:  shift_d = shift_q & 2'b01;
      kbd_xlat_pkg::SC_CAPS_MAKE:   toggle  = kbd_xlat_pkg::LED_CAPS;
      kbd_xlat_pkg::SC_NUM_MAKE:    toggle  = kbd_xlat_pkg::LED_NUM;
      kbd_xlat_pkg::SC_SCROLL_MAKE: toggle  = kbd_xlat_pkg::LED_SCROLL;
      kbd_xlat_pkg::KBD_ACK:        await_mid  = 1'b0;
      kbd_xlat_pkg::KBD_RESEND:     resend_hit = await_q;
      default: ;
    endcase
    leds_d = leds_q ^ toggle;

    // Send one queued byte when nothing is awaiting an acknowledge
    pop       = !resend_hit && !await_mid && q_stat.avail;
    send_vld  = resend_hit || pop;
    send_byte = resend_hit ? pend_q : (pop ? q_stat.head_byte : 8'h00);
    pend_d    = pop ? q_stat.head_byte : pend_q;
    await_d   = pop || await_mid;

    q_req.restart      = cfg_wr;
    q_req.restart_leds = cfg_data_i;
    q_req.push         = process && (toggle != 3'b000);
    q_req.push_leds    = leds_d;
    q_req.pop          = process && pop;
  end

  kbd_xlat_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (q_req),
    .stat_o (q_stat)
  );

  // Control state and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      shift_q   <= '0;
      leds_q    <= '0;
      await_q   <= 1'b0;
      pend_q    <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (process) begin
        in_vld_q <= 1'b0;
      end
      if (process) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_wr) begin
        shift_q <= '0;
        leds_q  <= cfg_data_i;
        await_q <= 1'b0;
        pend_q  <= '0;
      end else if (process) begin
        shift_q <= shift_d;
        leds_q  <= leds_d;
        await_q <= await_d;
        pend_q  <= pend_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_code_q <= s_axis_tdata;
    end
    if (process) begin
      out_data_q <= {1'b0, shift_d, leds_d, send_byte, send_vld, ch, (ch != 8'h00)};
    end
  end

endmodule

/* src/kbd_xlat_ram.sv */
module kbd_xlat_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port (old data on a collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/kbd_xlat_cmd_queue.sv */
module kbd_xlat_cmd_queue #(
  parameter int unsigned DEPTH = kbd_xlat_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kbd_xlat_pkg::queue_req_t req_i,
  output kbd_xlat_pkg::queue_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Byte count over the whole queue, row count behind the front row
  logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [CNT_W-1:0] ram_cnt_q, ram_cnt_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;

  // Front row in flops; offset 1 means the LED command already went out
  kbd_xlat_pkg::queue_row_t front_q, front_d;
  logic                     front_vld_q, front_vld_d;
  logic                     front_off_q, front_off_d;

  // Write-to-read bypass for a row written where the RAM is being read
  kbd_xlat_pkg::queue_row_t byp_row_q;
  logic                     byp_vld_q, byp_vld_d;

  kbd_xlat_pkg::queue_row_t new_row, head_row, ram_head, ram_rdata;
  logic                     room1, room2, push_row, head_off, exhaust, we, ram_pop;
  logic [CNT_W-1:0]         push_n;

  kbd_xlat_ram #(
    .WIDTH ($bits(kbd_xlat_pkg::queue_row_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_ptr_q),
    .wdata_i (new_row),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  // Push: LED command and LED byte; the LED byte alone is dropped when one byte is free, both when full
  always_comb begin
    room2            = byte_cnt_q <= CNT_W'(DEPTH - 2);
    room1            = byte_cnt_q < CNT_W'(DEPTH);
    push_row         = req_i.push && room1;
    new_row.has_led  = room2;
    new_row.leds     = req_i.push_leds;
    if (push_row) begin
      push_n = room2 ? CNT_W'(2) : CNT_W'(1);
    end else begin
      push_n = '0;
    end
  end

  // Head of queue, including a row pushed in this same request
  assign head_row = front_vld_q ? front_q : new_row;
  assign head_off = front_vld_q ? front_off_q : 1'b0;
  assign ram_head = byp_vld_q ? byp_row_q : ram_rdata;
  assign exhaust  = req_i.pop && (head_off || !head_row.has_led);

  assign stat_o.avail     = (byte_cnt_q != '0) || push_row;
  assign stat_o.head_byte = head_off ? {5'b0, head_row.leds} : kbd_xlat_pkg::LED_CMD;

  // Front row and RAM bookkeeping
  always_comb begin
    front_d     = front_q;
    front_vld_d = front_vld_q;
    front_off_d = front_off_q;
    we          = 1'b0;
    ram_pop     = 1'b0;
    if (front_vld_q) begin
      we = push_row && !(exhaust && ram_cnt_q == '0);
      if (exhaust) begin
        front_off_d = 1'b0;
        if (ram_cnt_q != '0) begin
          front_d = ram_head;
          ram_pop = 1'b1;
        end else if (push_row) begin
          front_d = new_row;
        end else begin
          front_vld_d = 1'b0;
        end
      end else if (req_i.pop) begin
        front_off_d = 1'b1;
      end
    end else if (push_row) begin
      front_d     = new_row;
      front_vld_d = !exhaust;
      front_off_d = req_i.pop && !exhaust;
    end

    byte_cnt_d = byte_cnt_q + push_n - CNT_W'(req_i.pop);
    ram_cnt_d  = ram_cnt_q + CNT_W'(we) - CNT_W'(ram_pop);

    rd_ptr_d = rd_ptr_q;
    if (ram_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    wr_ptr_d = wr_ptr_q;
    if (we) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end

    byp_vld_d = we && (wr_ptr_q == rd_ptr_d);

    // Restart: LED command and LED byte waiting in the front row
    if (req_i.restart) begin
      front_d.has_led = 1'b1;
      front_d.leds    = req_i.restart_leds;
      front_vld_d     = 1'b1;
      front_off_d     = 1'b0;
      byte_cnt_d      = CNT_W'(2);
      ram_cnt_d       = '0;
      rd_ptr_d        = '0;
      wr_ptr_d        = '0;
      we              = 1'b0;
      byp_vld_d       = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q.has_led <= 1'b1;
      front_q.leds    <= '0;
      front_vld_q     <= 1'b1;
      front_off_q     <= 1'b0;
      byte_cnt_q      <= CNT_W'(2);
      ram_cnt_q       <= '0;
      rd_ptr_q        <= '0;
      wr_ptr_q        <= '0;
      byp_vld_q       <= 1'b0;
    end else begin
      front_q     <= front_d;
      front_vld_q <= front_vld_d;
      front_off_q <= front_off_d;
      byte_cnt_q  <= byte_cnt_d;
      ram_cnt_q   <= ram_cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      byp_vld_q   <= byp_vld_d;
    end
  end

  // Bypass payload
  always_ff @(posedge clk_i) begin
    byp_row_q <= new_row;
  end

endmodule

/* test/keyboard_scan_code_translator_unit_test.sv */
`timescale 1ns / 100ps

module keyboard_scan_code_translator_unit_test;
  import kbd_xlat_pkg::*;

  // Result layout on m_axis_tdata, lowest bit last
  typedef struct packed {
    logic       pad;
    logic [1:0] shift_bits;
    logic [2:0] led_bits;
    logic [7:0] send_byte;
    logic       send_valid;
    logic [7:0] char_code;
    logic       char_valid;
  } xlat_result_t;

  // Character tables, scan code 0x00 in the top byte
  localparam logic [1023:0] PLAIN_CHARS = {
    128'h0000_3132_3334_3536_3738_3930_2D5E_0000,
    128'h5157_4552_5459_5549_4F50_405B_0000_4153,
    128'h4446_4748_4A4B_4C3B_3A00_005D_5A58_4356,
    128'h424E_4D2C_2E2F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0037_3839_2D34_3536_2B31,
    128'h3233_302E_0000_0000_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'h0000_005C_0000_0000_0000_0000_005C_0000
  };
  localparam logic [1023:0] SHIFT_CHARS = {
    128'h0000_2122_2324_2526_2728_297E_3D7E_0000,
    128'h5157_4552_5459_5549_4F50_607B_0000_4153,
    128'h4446_4748_4A4B_4C2B_2A00_007D_5A58_4356,
    128'h424E_4D3C_3E3F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0037_3839_2D34_3536_2B31,
    128'h3233_302E_0000_0000_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'h0000_005F_0000_0000_0000_0000_007C_0000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] scan_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [0] char_valid, [8:1] char_code, [9] send_valid,
                                       // [17:10] send_byte, [20:18] led_bits,
                                       // [22:21] shift_bits, [23] zero

  // Keyboard state as predicted
  logic [1:0]   kbd_shift;
  logic [2:0]   kbd_leds;
  logic         ack_wait;
  logic [7:0]   last_sent;
  logic [7:0]   cmd_fifo [QUEUE_DEPTH];
  int           fifo_head;
  int           fifo_count;

  logic [7:0]   scan_queue [$];
  xlat_result_t expected_results [$];
  xlat_result_t want, got;
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic         sender_paused = 1'b0;
  logic         steady_mode = 1'b0;

  keyboard_scan_code_translator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] char_lookup(input logic [1023:0] tbl, input logic [6:0] idx);
    return tbl[(127 - int'(idx)) * 8 +: 8];
  endfunction

  // Push one byte to the command fifo; dropped when full
  function automatic void push_cmd(input logic [7:0] b);
    if (fifo_count < QUEUE_DEPTH) begin
      cmd_fifo[(fifo_head + fifo_count) % QUEUE_DEPTH] = b;
      fifo_count++;
    end
  endfunction

  function automatic void restart_keyboard(input logic [2:0] leds);
    kbd_shift = 2'b00;
    kbd_leds = leds;
    ack_wait = 1'b0;
    last_sent = 8'h00;
    fifo_head = 0;
    fifo_count = 0;
    push_cmd(LED_CMD);
    push_cmd({5'd0, leds});
  endfunction

  function automatic void toggle_lock(input logic [2:0] bit_mask);
    kbd_leds = kbd_leds ^ bit_mask;
    push_cmd(LED_CMD);
    push_cmd({5'd0, kbd_leds});
  endfunction

  // Advance the keyboard state by one scan byte and give its result
  function automatic xlat_result_t translate_scan(input logic [7:0] code);
    xlat_result_t r;
    logic [7:0]   ch;
    logic         sent_now;
    logic [7:0]   sent;
    ch = 8'h00;
    sent_now = 1'b0;
    sent = 8'h00;
    if (!code[7]) begin
      ch = (kbd_shift == 2'b00) ? char_lookup(PLAIN_CHARS, code[6:0])
                                : char_lookup(SHIFT_CHARS, code[6:0]);
      // lower case unless exactly one of caps lock and shift holds
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z && (kbd_leds[2] == (kbd_shift != 2'b00)))
        ch = ch + CH_CASE_OFS;
    end
    if (code == SC_BACKSPACE) ch = CH_BACKSPACE;
    if (code == SC_ENTER) ch = CH_NEWLINE;
    case (code)
      SC_LSHIFT_MAKE: kbd_shift[0] = 1'b1;
      SC_RSHIFT_MAKE: kbd_shift[1] = 1'b1;
      SC_LSHIFT_BRK:  kbd_shift[0] = 1'b0;
      SC_RSHIFT_BRK:  kbd_shift[1] = 1'b0;
      SC_CAPS_MAKE:   toggle_lock(LED_CAPS);
      SC_NUM_MAKE:    toggle_lock(LED_NUM);
      SC_SCROLL_MAKE: toggle_lock(LED_SCROLL);
      KBD_ACK:        ack_wait = 1'b0;
      KBD_RESEND: begin
        if (ack_wait) begin
          sent_now = 1'b1;
          sent = last_sent;
        end
      end
      default: ;
    endcase
    // one queued byte goes out when nothing waits for an ack
    if (!sent_now && !ack_wait && fifo_count > 0) begin
      last_sent = cmd_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
      fifo_count--;
      ack_wait = 1'b1;
      sent_now = 1'b1;
      sent = last_sent;
    end
    r.pad = 1'b0;
    r.char_valid = (ch != 8'h00);
    r.char_code = ch;
    r.send_valid = sent_now;
    r.send_byte = sent;
    r.led_bits = kbd_leds;
    r.shift_bits = kbd_shift;
    return r;
  endfunction

  // Request driver: holds a byte until taken, then maybe idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(translate_scan(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (scan_queue.size() > 0 && !sender_paused &&
            (steady_mode || $urandom_range(99) >= 35)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= scan_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d not expected: %h", results_seen, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
              got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
              got.led_bits !== want.led_bits || got.shift_bits !== want.shift_bits) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result %0d mismatch: want cv=%b ch=%h sv=%b sb=%h led=%b sh=%b",
                       results_seen, want.char_valid, want.char_code, want.send_valid,
                       want.send_byte, want.led_bits, want.shift_bits);
              $display("  got cv=%b ch=%h sv=%b sb=%h led=%b sh=%b",
                       got.char_valid, got.char_code, got.send_valid, got.send_byte,
                       got.led_bits, got.shift_bits);
            end
          end
        end
        // one long hold-off so the block backs up into its input
        if (results_seen == 150 && !hold_done) begin
          hold_left = 120;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady_mode || ($urandom_range(99) >= 35);
      end
    end
  end

  // Random keyboard traffic, mostly well-formed with acks mixed in
  task automatic queue_random(input int n);
    int         k;
    int         burst;
    int         pick;
    int         sel;
    logic [7:0] code;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      sel = $urandom_range(3);
      if (pick < 4) begin
        // run of lock keys with no acks: overfills the command fifo
        burst = $urandom_range(24, 17);
        repeat (burst) begin
          sel = $urandom_range(2);
          scan_queue.push_back(sel == 0 ? SC_CAPS_MAKE : sel == 1 ? SC_NUM_MAKE
                                                                  : SC_SCROLL_MAKE);
        end
        k += burst;
      end else begin
        if (pick < 30)
          code = KBD_ACK;
        else if (pick < 36)
          code = KBD_RESEND;
        else if (pick < 48)
          code = sel == 0 ? SC_LSHIFT_MAKE : sel == 1 ? SC_RSHIFT_MAKE :
                 sel == 2 ? SC_LSHIFT_BRK : SC_RSHIFT_BRK;
        else if (pick < 55)
          code = sel == 0 ? SC_CAPS_MAKE : sel == 1 ? SC_NUM_MAKE : SC_SCROLL_MAKE;
        else if (pick < 80)
          code = 8'($urandom_range(127));
        else
          code = 8'($urandom_range(255));
        scan_queue.push_back(code);
        k++;
      end
    end
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_idle();
    while (scan_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_leds(input logic [2:0] leds);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= leds;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    restart_keyboard(leds);
  endtask

  initial begin
    restart_keyboard(3'd0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: resend/ack corners, shifts, locks, table edges
    scan_queue = '{8'h1E, KBD_RESEND, KBD_ACK, KBD_ACK, KBD_RESEND, KBD_ACK,
                   SC_LSHIFT_MAKE, 8'h1E, 8'h02, SC_RSHIFT_MAKE, SC_LSHIFT_BRK, 8'h7D,
                   SC_RSHIFT_BRK, SC_CAPS_MAKE, 8'h1E, SC_LSHIFT_MAKE, 8'h1E,
                   SC_LSHIFT_BRK, SC_NUM_MAKE, SC_SCROLL_MAKE, SC_BACKSPACE, SC_ENTER,
                   8'h00, 8'h7F, 8'h80, 8'hFF};
    queue_random(160);
    wait_idle();

    // LED extremes first, then random settings
    write_leds(3'd7);
    @(negedge clk_i);
    queue_random(90);
    // sender stops until the block has drained
    while (scan_queue.size() >= 45) @(negedge clk_i);
    sender_paused = 1'b1;
    while (s_axis_tvalid || expected_results.size() > 0) @(negedge clk_i);
    sender_paused = 1'b0;
    wait_idle();

    write_leds(3'd0);
    @(negedge clk_i);
    steady_mode = 1'b1;
    queue_random(170);
    wait_idle();
    steady_mode = 1'b0;

    write_leds(3'd5);
    @(negedge clk_i);
    queue_random(170);
    wait_idle();

    repeat (2) begin
      write_leds(3'($urandom_range(7)));
      @(negedge clk_i);
      queue_random(170);
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/kbd_xlat_pkg.sv
src/kbd_xlat_ram.sv
src/kbd_xlat_cmd_queue.sv
src/keyboard_scan_code_translator_unit.sv
test/keyboard_scan_code_translator_unit_test.sv
